/* rtl/mrcr_pkg.sv */
// ---------------------------------------------------------------------------
// mrcr_pkg: shared types and constants for the row/column reduction block
// Operation codes, register addresses, field widths, controller commands.
// ---------------------------------------------------------------------------
package mrcr_pkg;

  localparam int MAX_DIM_DEF      = 16;
  localparam int ELEMENT_BITS_DEF = 16;
  localparam int RESULT_BITS      = 40;
  localparam int INDEX_BITS       = 4;
  localparam int OP_BITS          = 3;
  localparam int CNT_BITS         = 5;
  localparam int ADDR_BITS        = 5;

  localparam logic [OP_BITS-1:0] OP_SUM  = 3'd0;
  localparam logic [OP_BITS-1:0] OP_MEAN = 3'd1;
  localparam logic [OP_BITS-1:0] OP_VAR  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_MIN  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_MAX  = 3'd4;

  localparam logic [ADDR_BITS-1:0] REG_OPERATION = 5'd0;
  localparam logic [ADDR_BITS-1:0] REG_AXIS      = 5'd4;
  localparam logic [ADDR_BITS-1:0] REG_COMPLEX   = 5'd8;
  localparam logic [ADDR_BITS-1:0] REG_ROWS      = 5'd12;
  localparam logic [ADDR_BITS-1:0] REG_COLS      = 5'd16;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // register incoming item, compute |z|^2
    logic rd_bank;     // read bank entry of current group
    logic update;      // write accumulated values back
    logic div_start;   // start finishing division(s)
    logic load_out;    // load output register
  } mrcr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;        // item closes its group
    logic div_busy;
    logic out_full;
  } mrcr_sts_t;

endpackage

/* rtl/matrix_row_column_reduce.sv */
// ---------------------------------------------------------------------------
// matrix_row_column_reduce: streamed row/column sum, mean, variance, min, max
// Signed Q8.8 elements in row-major order; one result per group end.
// ---------------------------------------------------------------------------
// An element that does not close a group steps through capture, bank read
//   and bank write; input ready returns after the bank write.
// A group-closing element adds sum squaring, divider start, the run of the two
//   44-bit dividers and output load, plus any wait on a full output.
// Each item's bank read-modify-write ends before the next item is taken.
// Reset: synchronous, active low; configuration returns to sum, rows, 1x1;
//   bank contents stay undefined and are written by each group's first item.
module matrix_row_column_reduce #(
  parameter int MAX_DIM      = mrcr_pkg::MAX_DIM_DEF,
  parameter int ELEMENT_BITS = mrcr_pkg::ELEMENT_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // configuration port
  input  logic                                    cfg_psel,
  input  logic                                    cfg_penable,
  input  logic                                    cfg_pwrite,
  input  logic [mrcr_pkg::ADDR_BITS-1:0]          cfg_paddr,
  input  logic [31:0]                             cfg_pwdata,
  output logic [31:0]                             cfg_prdata,
  output logic                                    cfg_pready,
  // input items
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [ELEMENT_BITS-1:0]          in_elem_real,
  input  logic signed [ELEMENT_BITS-1:0]          in_elem_imag,
  // result items
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [mrcr_pkg::INDEX_BITS-1:0]         out_group_index,
  output logic signed [mrcr_pkg::RESULT_BITS-1:0] out_result_real,
  output logic signed [mrcr_pkg::RESULT_BITS-1:0] out_result_imag,
  output logic                                    out_var_undefined,
  output logic                                    out_last_of_matrix
);
  import mrcr_pkg::*;

  logic [OP_BITS-1:0]  operation_r;
  logic                axis_r, complex_r;
  logic [CNT_BITS-1:0] rows_r, cols_r;
  logic                wr_en, cfg_hit;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;

  // register decode; a write to any listed register restarts the matrix
  always_comb begin
    cfg_prdata = '0;
    cfg_hit    = 1'b1;
    unique case (cfg_paddr)
      REG_OPERATION: cfg_prdata = 32'(operation_r);
      REG_AXIS:      cfg_prdata = 32'(axis_r);
      REG_COMPLEX:   cfg_prdata = 32'(complex_r);
      REG_ROWS:      cfg_prdata = 32'(rows_r);
      REG_COLS:      cfg_prdata = 32'(cols_r);
      default:       cfg_hit    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operation_r <= OP_SUM;
      axis_r      <= 1'b0;
      complex_r   <= 1'b0;
      rows_r      <= CNT_BITS'(1);
      cols_r      <= CNT_BITS'(1);
    end else if (wr_en) begin
      unique case (cfg_paddr)
        REG_OPERATION: operation_r <= cfg_pwdata[OP_BITS-1:0];
        REG_AXIS:      axis_r      <= cfg_pwdata[0];
        REG_COMPLEX:   complex_r   <= cfg_pwdata[0];
        REG_ROWS:      rows_r      <= cfg_pwdata[CNT_BITS-1:0];
        REG_COLS:      cols_r      <= cfg_pwdata[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  mrcr_cmd_t cmd;
  mrcr_sts_t sts;

  mrcr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  mrcr_dp #(.MAX_DIM(MAX_DIM), .ELEMENT_BITS(ELEMENT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_wr(wr_en & cfg_hit),
    .operation(operation_r), .axis_select(axis_r), .complex_mode(complex_r),
    .row_count(rows_r), .col_count(cols_r),
    .in_elem_real(in_elem_real), .in_elem_imag(in_elem_imag),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_group_index(out_group_index),
    .out_result_real(out_result_real), .out_result_imag(out_result_imag),
    .out_var_undefined(out_var_undefined),
    .out_last_of_matrix(out_last_of_matrix)
  );
endmodule

/* rtl/mrcr_ram.sv */
// ---------------------------------------------------------------------------
// mrcr_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module mrcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/mrcr_div.sv */
// ---------------------------------------------------------------------------
// mrcr_div: sequenced restoring divider
// Unsigned numerator by unsigned denominator, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mrcr_div #(
  parameter int NUM_BITS = 48,
  parameter int DEN_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                busy,
  output logic [NUM_BITS-1:0] quot
);
  localparam int CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] quot_r, quot_nxt;
  logic [DEN_BITS:0]   rem_r, rem_nxt;
  logic [DEN_BITS-1:0] den_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic [DEN_BITS:0]   trial;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[DEN_BITS-1:0], quot_r[NUM_BITS-1]};
    if (start) begin
      quot_nxt = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NUM_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt  = trial - {1'b0, den_r};
        quot_nxt = {quot_r[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt  = trial;
        quot_nxt = {quot_r[NUM_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;
endmodule

/* rtl/mrcr_ctrl.sv */
// ---------------------------------------------------------------------------
// mrcr_ctrl: sequencing controller
// Steps each item through capture, bank read, update and optional division.
// ---------------------------------------------------------------------------
module mrcr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrcr_pkg::mrcr_sts_t sts,
  output mrcr_pkg::mrcr_cmd_t cmd
);
  import mrcr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_UPDATE, S_SQUARE, S_DIVSTART, S_DIVWAIT, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_bank = 1'b1;
        state_nxt   = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = sts.last ? S_SQUARE : S_IDLE;
      end
      // datapath registers the squared sums of the updated group
      S_SQUARE: begin
        state_nxt = S_DIVSTART;
      end
      S_DIVSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!sts.out_full) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

/* rtl/mrcr_dp.sv */
// ---------------------------------------------------------------------------
// mrcr_dp: reduction datapath
// Position counters, per-group banks, finishing arithmetic, output register.
// ---------------------------------------------------------------------------
module mrcr_dp #(
  parameter int MAX_DIM      = mrcr_pkg::MAX_DIM_DEF,
  parameter int ELEMENT_BITS = mrcr_pkg::ELEMENT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mrcr_pkg::mrcr_cmd_t                  cmd,
  output mrcr_pkg::mrcr_sts_t                  sts,
  input  logic                                 cfg_wr,
  input  logic [mrcr_pkg::OP_BITS-1:0]         operation,
  input  logic                                 axis_select,
  input  logic                                 complex_mode,
  input  logic [mrcr_pkg::CNT_BITS-1:0]        row_count,
  input  logic [mrcr_pkg::CNT_BITS-1:0]        col_count,
  input  logic signed [ELEMENT_BITS-1:0]       in_elem_real,
  input  logic signed [ELEMENT_BITS-1:0]       in_elem_imag,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mrcr_pkg::INDEX_BITS-1:0]      out_group_index,
  output logic signed [mrcr_pkg::RESULT_BITS-1:0] out_result_real,
  output logic signed [mrcr_pkg::RESULT_BITS-1:0] out_result_imag,
  output logic                                 out_var_undefined,
  output logic                                 out_last_of_matrix
);
  import mrcr_pkg::*;

  localparam int PW  = $clog2(MAX_DIM);
  localparam int NW  = $clog2(MAX_DIM + 1);
  localparam int EB  = ELEMENT_BITS;
  localparam int SB  = EB + NW;           // sum width
  localparam int MB  = 2 * EB + 1;        // |z|^2 width
  localparam int QB  = MB + NW;           // square sum width
  localparam int DNB = 2 * NW;            // n*(n-1) width
  localparam int VNB = QB + NW + 1;       // variance numerator width
  localparam int DVB = (VNB > SB + 9) ? VNB : SB + 9;
  localparam int BW  = 2 * SB + QB + 2 * EB + MB;

  // effective counts
  logic [NW-1:0] r_eff, c_eff, n_eff;
  always_comb begin
    if (row_count == '0) r_eff = NW'(1);
    else if (32'(row_count) > MAX_DIM) r_eff = NW'(MAX_DIM);
    else r_eff = NW'(row_count);
    if (col_count == '0) c_eff = NW'(1);
    else if (32'(col_count) > MAX_DIM) c_eff = NW'(MAX_DIM);
    else c_eff = NW'(col_count);
    n_eff = axis_select ? r_eff : c_eff;
  end

  // positions
  logic [PW-1:0] row_r, col_r, row_nxt, col_nxt, r_cur, c_cur, grp;
  logic first, last, fin;
  always_comb begin
    r_cur = (NW'(row_r) >= r_eff) ? '0 : row_r;
    c_cur = (NW'(col_r) >= c_eff) ? '0 : col_r;
    grp   = axis_select ? c_cur : r_cur;
    first = axis_select ? (r_cur == '0) : (c_cur == '0);
    last  = axis_select ? (NW'(r_cur) == r_eff - 1'b1) : (NW'(c_cur) == c_eff - 1'b1);
    fin   = (NW'(r_cur) == r_eff - 1'b1) && (NW'(c_cur) == c_eff - 1'b1);
    row_nxt = r_cur;
    col_nxt = c_cur + 1'b1;
    if (NW'(c_cur) == c_eff - 1'b1) begin
      col_nxt = '0;
      row_nxt = (NW'(r_cur) == r_eff - 1'b1) ? '0 : r_cur + 1'b1;
    end
  end

  // captured item
  logic signed [EB-1:0] re_r, im_r;
  logic [MB-1:0]        msq_r;
  logic [PW-1:0]        grp_r;
  logic first_r, last_r, fin_r;
  logic signed [EB-1:0] im_sel;
  logic signed [2*EB-1:0] sqr, sqi;
  assign im_sel = complex_mode ? in_elem_imag : '0;
  assign sqr = in_elem_real * in_elem_real;
  assign sqi = im_sel * im_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cfg_wr) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.capture) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
    if (cmd.capture) begin
      re_r    <= in_elem_real;
      im_r    <= im_sel;
      msq_r   <= MB'($unsigned(sqr)) + MB'($unsigned(sqi));
      grp_r   <= grp;
      first_r <= first;
      last_r  <= last;
      fin_r   <= fin;
    end
  end

  // bank memory: one row per group
  logic [BW-1:0] bank_rd, bank_wr;
  logic signed [SB-1:0] b_sr, b_si, n_sr, n_si;
  logic [QB-1:0]        b_q, n_q;
  logic signed [EB-1:0] b_er, b_ei, n_er, n_ei;
  logic [MB-1:0]        b_em, n_em;
  logic take;

  assign {b_sr, b_si, b_q, b_er, b_ei, b_em} = bank_rd;

  mrcr_ram #(.WIDTH(BW), .DEPTH(1 << PW)) u_bank (
    .clk  (clk),
    .we   (cmd.update),
    .waddr(grp_r),
    .wdata(bank_wr),
    .raddr(grp_r),
    .rdata(bank_rd)
  );

  always_comb begin
    take = 1'b0;
    if (operation == OP_MIN) begin
      take = complex_mode ? (msq_r < b_em) : (re_r < b_er);
    end else if (operation == OP_MAX) begin
      take = complex_mode ? (msq_r > b_em) : (re_r > b_er);
    end
    if (first_r) begin
      n_sr = SB'(re_r);
      n_si = SB'(im_r);
      n_q  = QB'(msq_r);
    end else begin
      n_sr = b_sr + SB'(re_r);
      n_si = b_si + SB'(im_r);
      n_q  = b_q + QB'(msq_r);
    end
    if (first_r || take) begin
      n_er = re_r;
      n_ei = im_r;
      n_em = msq_r;
    end else begin
      n_er = b_er;
      n_ei = b_ei;
      n_em = b_em;
    end
    bank_wr = {n_sr, n_si, n_q, n_er, n_ei, n_em};
  end

  // finishing: held values after update
  logic signed [SB-1:0] h_sr, h_si;
  logic [QB-1:0]        h_q;
  logic signed [EB-1:0] h_er, h_ei;
  logic signed [2*SB-1:0] p_sr, p_si;
  logic [2*SB-1:0]      s2_r;
  logic [VNB-1:0]       nq_r;
  assign p_sr = h_sr * h_sr;
  assign p_si = h_si * h_si;
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      h_sr <= n_sr;
      h_si <= n_si;
      h_q  <= n_q;
      h_er <= n_er;
      h_ei <= n_ei;
    end
    // second stage products, registered in the cycle after the held values
    s2_r <= $unsigned(p_sr) + $unsigned(p_si);
    nq_r <= VNB'(h_q) * VNB'(n_eff);
  end

  // dividers: real and imaginary share one sequence
  logic [DVB-1:0] num_a, num_b, q_a, q_b;
  logic [DNB-1:0] den;
  logic neg_a, neg_b, busy_a, busy_b;
  logic neg_a_r, neg_b_r;
  logic signed [SB+8:0] sc_r, sc_i;
  assign sc_r = {h_sr[SB-1], h_sr, 8'd0};
  assign sc_i = {h_si[SB-1], h_si, 8'd0};
  always_comb begin
    neg_a = 1'b0;
    neg_b = 1'b0;
    if (operation == OP_VAR) begin
      num_a = DVB'(nq_r - VNB'(s2_r));
      num_b = '0;
      den   = DNB'(n_eff) * DNB'(n_eff - 1'b1);
    end else begin
      neg_a = sc_r[SB+8];
      neg_b = sc_i[SB+8];
      num_a = DVB'(neg_a ? -sc_r : sc_r);
      num_b = DVB'(neg_b ? -sc_i : sc_i);
      den   = DNB'(n_eff);
    end
  end

  mrcr_div #(.NUM_BITS(DVB), .DEN_BITS(DNB)) u_div_a (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(num_a), .den(den), .busy(busy_a), .quot(q_a)
  );
  mrcr_div #(.NUM_BITS(DVB), .DEN_BITS(DNB)) u_div_b (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(num_b), .den(den), .busy(busy_b), .quot(q_b)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_a_r <= neg_a;
      neg_b_r <= neg_b;
    end
  end

  // result select
  logic signed [RESULT_BITS-1:0] res_r, res_i;
  logic undef;
  always_comb begin
    undef = 1'b0;
    unique case (operation)
      OP_MEAN: begin
        res_r = neg_a_r ? -RESULT_BITS'(q_a) : RESULT_BITS'(q_a);
        res_i = neg_b_r ? -RESULT_BITS'(q_b) : RESULT_BITS'(q_b);
      end
      OP_VAR: begin
        res_i = '0;
        if (n_eff < NW'(2)) begin
          undef = 1'b1;
          res_r = '0;
        end else begin
          res_r = RESULT_BITS'(q_a);
        end
      end
      OP_MIN, OP_MAX: begin
        res_r = RESULT_BITS'($signed({h_er, 8'd0}));
        res_i = RESULT_BITS'($signed({h_ei, 8'd0}));
      end
      default: begin
        res_r = RESULT_BITS'(sc_r);
        res_i = RESULT_BITS'(sc_i);
      end
    endcase
    if (!complex_mode) res_i = '0;
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_group_index    <= INDEX_BITS'(grp_r);
      out_result_real    <= res_r;
      out_result_imag    <= res_i;
      out_var_undefined  <= undef;
      out_last_of_matrix <= fin_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.last     = last_r;
  assign sts.div_busy = busy_a | busy_b;
  assign sts.out_full = out_valid_r & ~out_ready;
endmodule

/* dv/matrix_row_column_reduce_test.sv */
// ---------------------------------------------------------------------------
// matrix_row_column_reduce_test: self-checking bench for the reduction block
// Streams matrices through the block under several register settings, keeps
// its own running model of the per-group sums and extremes, and checks every
// result item field by field against the queue of expected results.
// ---------------------------------------------------------------------------
module matrix_row_column_reduce_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mrcr_pkg::*;

  localparam int DIM = 16;

  typedef struct packed {
    logic [INDEX_BITS-1:0]         grp;
    logic signed [RESULT_BITS-1:0] re;
    logic signed [RESULT_BITS-1:0] im;
    logic                          undef;
    logic                          last;
  } reduce_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [ADDR_BITS-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_elem_real = '0, in_elem_imag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [INDEX_BITS-1:0] out_group_index;
  logic signed [RESULT_BITS-1:0] out_result_real, out_result_imag;
  logic out_var_undefined, out_last_of_matrix;

  matrix_row_column_reduce dut (.*);

  always #5 clk = ~clk;

  // shadow of the block's registers and position
  logic [2:0] op_sh;
  logic by_col_sh, cpx_sh;
  logic [4:0] rows_sh, cols_sh;
  int unsigned row_at, col_at;
  longint sum_re[DIM], sum_im[DIM], ext_re[DIM], ext_im[DIM];
  longint unsigned sq_sum[DIM], ext_mag[DIM];

  reduce_result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;

  // item accepted on either channel resets the watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("matrix_row_column_reduce verification failed");
      $finish;
    end
  end

  function automatic int unsigned clamp_count(logic [4:0] c);
    if (c == 0) return 1;
    if (c > DIM) return DIM;
    return c;
  endfunction

  // predict the result (if any) caused by one element
  function automatic void predict_element(logic signed [15:0] er, logic signed [15:0] ei);
    int unsigned nr, nc, r, c, g, n;
    bit first, closes, fin, take;
    longint re, im, rr, ri, sr, si;
    longint unsigned msq, num;
    reduce_result_t res;
    nr = clamp_count(rows_sh);
    nc = clamp_count(cols_sh);
    if (row_at >= nr) row_at = 0;
    if (col_at >= nc) col_at = 0;
    r = row_at;
    c = col_at;
    g = by_col_sh ? c : r;
    n = by_col_sh ? nr : nc;
    first = by_col_sh ? (r == 0) : (c == 0);
    closes = by_col_sh ? (r == nr - 1) : (c == nc - 1);
    fin = (r == nr - 1) && (c == nc - 1);
    re = er;
    im = cpx_sh ? longint'(ei) : 0;
    msq = re * re + im * im;
    if (first) begin
      sum_re[g] = re; sum_im[g] = im; sq_sum[g] = msq;
      ext_re[g] = re; ext_im[g] = im; ext_mag[g] = msq;
    end else begin
      sum_re[g] += re; sum_im[g] += im; sq_sum[g] += msq;
      take = 0;
      if (op_sh == OP_MIN) take = cpx_sh ? (msq < ext_mag[g]) : (re < ext_re[g]);
      else if (op_sh == OP_MAX) take = cpx_sh ? (msq > ext_mag[g]) : (re > ext_re[g]);
      if (take) begin
        ext_re[g] = re; ext_im[g] = im; ext_mag[g] = msq;
      end
    end
    col_at = c + 1;
    if (col_at >= nc) begin
      col_at = 0;
      row_at = (r + 1 >= nr) ? 0 : r + 1;
    end
    if (!closes) return;
    rr = 0; ri = 0; res.undef = 0;
    case (op_sh)
      OP_MEAN: begin
        rr = (sum_re[g] * 256) / longint'(n);
        ri = (sum_im[g] * 256) / longint'(n);
      end
      OP_VAR: begin
        if (n < 2) res.undef = 1;
        else begin
          sr = sum_re[g]; si = sum_im[g];
          num = longint'(n) * sq_sum[g] - longint'(sr * sr + si * si);
          rr = num / (longint'(n) * longint'(n - 1));
        end
      end
      OP_MIN, OP_MAX: begin
        rr = ext_re[g] * 256;
        ri = ext_im[g] * 256;
      end
      default: begin
        rr = sum_re[g] * 256;
        ri = sum_im[g] * 256;
      end
    endcase
    if (!cpx_sh) ri = 0;
    res.grp = g[3:0];
    res.re = rr[RESULT_BITS-1:0];
    res.im = ri[RESULT_BITS-1:0];
    res.last = fin;
    expected_results.push_back(res);
  endfunction

  // result checker with random backpressure
  always @(posedge clk) begin
    reduce_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result grp=%0d re=%0d", $time, out_group_index,
                 out_result_real);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_group_index !== want.grp) begin
          $display("%0t: group_index exp %0d got %0d", $time, want.grp, out_group_index);
          errors++;
        end
        if (out_result_real !== want.re) begin
          $display("%0t: result_real exp %0d got %0d", $time, want.re, out_result_real);
          errors++;
        end
        if (out_result_imag !== want.im) begin
          $display("%0t: result_imag exp %0d got %0d", $time, want.im, out_result_imag);
          errors++;
        end
        if (out_var_undefined !== want.undef) begin
          $display("%0t: var_undefined exp %0b got %0b", $time, want.undef,
                   out_var_undefined);
          errors++;
        end
        if (out_last_of_matrix !== want.last) begin
          $display("%0t: last_of_matrix exp %0b got %0b", $time, want.last,
                   out_last_of_matrix);
          errors++;
        end
      end
    end
  end

  int stall_left = 0;
  bit calm_out = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm_out && $urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  bit calm_in = 0;

  // valid stays up after an accept until the next item or an idle gap drops it
  task automatic send_element(logic signed [15:0] er, logic signed [15:0] ei);
    int gap;
    gap = calm_in ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_elem_real <= er;
    in_elem_imag <= ei;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_element(er, ei);
  endtask

  // write only when idle; the drain covers a divider run still in flight
  task automatic write_reg(logic [ADDR_BITS-1:0] addr, logic [31:0] value);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (addr)
      REG_OPERATION: op_sh = value[2:0];
      REG_AXIS:      by_col_sh = value[0];
      REG_COMPLEX:   cpx_sh = value[0];
      REG_ROWS:      rows_sh = value[4:0];
      default:       cols_sh = value[4:0];
    endcase
    row_at = 0;
    col_at = 0;
  endtask

  task automatic configure(logic [2:0] op, bit axis, bit cpx, logic [4:0] nr, logic [4:0] nc);
    write_reg(REG_OPERATION, op);
    write_reg(REG_AXIS, axis);
    write_reg(REG_COMPLEX, cpx);
    write_reg(REG_ROWS, nr);
    write_reg(REG_COLS, nc);
  endtask

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_matrix();
    int k;
    k = clamp_count(rows_sh) * clamp_count(cols_sh);
    repeat (k) send_element(rand_field(), rand_field());
  endtask

  // extremes of the fields, every operation, ties, one-element variance
  task automatic test_directed();
    configure(OP_SUM, 0, 1, 2, 2);
    send_element(16'sh7fff, 16'sh8000); send_element(16'sh7fff, 16'sh8000);
    send_element(16'sh8000, 16'sh7fff); send_element(16'sh8000, 16'sh7fff);
    write_reg(REG_OPERATION, OP_VAR);
    write_reg(REG_COLS, 1);                  // group of one: variance undefined
    send_element(16'sh1234, 16'sh0055); send_element(16'shedcb, 16'sh00aa);
    write_reg(REG_OPERATION, OP_MIN);
    write_reg(REG_COLS, 3);                  // equal magnitudes: first one wins
    send_element(16'sh0300, 16'sh0400); send_element(16'sh0500, 16'sh0000);
    send_element(16'sh0000, 16'shfb00);
    write_reg(REG_OPERATION, OP_MAX);
    send_element(16'sh0300, 16'sh0400); send_element(16'sh0000, 16'sh0500);
    send_element(16'shffff, 16'sh0001);
    write_reg(REG_OPERATION, OP_MEAN);
    write_reg(REG_COMPLEX, 0);
    send_element(-16'sd7, 16'sh7fff); send_element(16'sd0, 16'sh0); send_element(16'sd3, 16'sh1);
    write_reg(REG_OPERATION, 7);             // undefined code behaves as sum
    write_reg(REG_ROWS, 0);                  // zero count saturates to one
    send_element(16'sh0101, 16'sh0); send_element(16'sh8000, 16'sh0);
    send_element(16'sh7fff, 16'sh0);
    write_reg(REG_COLS, 31);                 // oversize count saturates to max
    repeat (DIM) send_element(16'sh8000, 16'sh8000);
  endtask

  // full 16x16 in both axes, variance over the largest groups
  task automatic test_largest();
    configure(OP_VAR, 1, 1, 16, 16);
    send_matrix();
    configure(OP_MAX, 0, 0, 16, 16);
    send_matrix();
  endtask

  task automatic test_random(int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      configure($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 5),
                $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 5));
      calm_in = ($urandom_range(0, 4) == 0);
      calm_out = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 4)) begin
        send_matrix();
        sent += clamp_count(rows_sh) * clamp_count(cols_sh);
      end
      // a partial matrix, cut short by the next register write
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) begin
        send_element(rand_field(), rand_field());
        sent++;
      end
    end
    calm_in = 0;
    calm_out = 0;
  endtask

  initial begin
    op_sh = OP_SUM; by_col_sh = 0; cpx_sh = 0; rows_sh = 1; cols_sh = 1;
    row_at = 0; col_at = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_largest();
    test_random(1100);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("matrix_row_column_reduce verification clean");
    else
      $display("matrix_row_column_reduce verification failed");
    $finish;
  end
endmodule

/* filelist.f */
rtl/mrcr_pkg.sv
rtl/mrcr_ram.sv
rtl/mrcr_div.sv
rtl/mrcr_ctrl.sv
rtl/mrcr_dp.sv
rtl/matrix_row_column_reduce.sv
dv/matrix_row_column_reduce_test.sv
